// File: design/aqbc_pkg.sv
`timescale 1ns / 1ps

package aqbc_pkg;

   // Sensor sample width; the reference and raw echo share it.
   localparam int SAMPLE_BITS = 10;
   // Running sum of up to three samples.
   localparam int SUM_BITS    = SAMPLE_BITS + 2;
   localparam int CFG_BITS    = 10;
   localparam int CSR_IDX_BITS = 2;

   localparam int CAL_SAMPLES   = 3;
   localparam int CAL_MIN_LEVEL = 10;
   localparam int CAL_MAX_DEV   = 15;

   // floor(x / 3) == (x * 2731) >> 13 for every x below 2**12.
   localparam int DIV3_RECIP = 2731;
   localparam int DIV3_SHIFT = 13;
   localparam int PROD_BITS  = SUM_BITS + 12;

   localparam logic [1:0] MODE_CAL  = 2'd0;
   localparam logic [1:0] MODE_EVAL = 2'd1;
   localparam logic [1:0] MODE_RAW  = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_BAD_AIR  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HIGH_OFS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOW_OFS  = 2'd2;

   localparam logic [CFG_BITS-1:0] BAD_AIR_RESET  = 10'd700;
   localparam logic [CFG_BITS-1:0] HIGH_OFS_RESET = 10'd400;
   localparam logic [CFG_BITS-1:0] LOW_OFS_RESET  = 10'd200;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_NOT_INIT     = 3'd1,
      STATUS_OUT_OF_RANGE = 3'd2,
      STATUS_UNSTABLE     = 3'd3,
      STATUS_CALIBRATING  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      QUALITY_GOOD      = 2'd0,
      QUALITY_LOW       = 2'd1,
      QUALITY_HIGH      = 2'd2,
      QUALITY_VERY_HIGH = 2'd3
   } quality_type;

   // Next state produced by one calibration beat.
   typedef struct packed {
      status_type             status;
      logic [SAMPLE_BITS-1:0] baseline;
      logic                   ready;
      logic [1:0]             count;
      logic [SUM_BITS-1:0]    sum;
      logic                   store_en;
      logic                   store_idx;
   } cal_out_type;

   // Grade and baseline tracking for an evaluate or raw beat.
   typedef struct packed {
      quality_type            quality;
      logic [SAMPLE_BITS-1:0] baseline;
   } eval_out_type;

endpackage

// File: design/aqbc_cal.sv
`timescale 1ns / 1ps

// Calibration step: accumulate, average the three samples and check them.
module aqbc_cal (
   input  logic [aqbc_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [1:0]                       count,
   input  logic [aqbc_pkg::SUM_BITS-1:0]    sum,
   input  logic                             ready,
   input  logic [aqbc_pkg::SAMPLE_BITS-1:0] baseline,
   input  logic [aqbc_pkg::SAMPLE_BITS-1:0] cal_sample0,
   input  logic [aqbc_pkg::SAMPLE_BITS-1:0] cal_sample1,
   input  logic [aqbc_pkg::CFG_BITS-1:0]    very_high_level,
   output aqbc_pkg::cal_out_type            cal_out
);

   logic                             first;
   logic                             fill;
   logic [aqbc_pkg::SUM_BITS-1:0]    total;
   logic [aqbc_pkg::PROD_BITS-1:0]   prod;
   logic [aqbc_pkg::SAMPLE_BITS-1:0] avg;
   logic [aqbc_pkg::SAMPLE_BITS-1:0] dev0;
   logic [aqbc_pkg::SAMPLE_BITS-1:0] dev1;
   logic [aqbc_pkg::SAMPLE_BITS-1:0] dev2;
   logic                             range_bad;
   logic                             dev_bad;
   logic                             ready_kept;

   always_comb begin
      first = (count == 2'd0);
      fill  = (count < 2'(aqbc_pkg::CAL_SAMPLES - 1));
      total = (first ? '0 : sum) + aqbc_pkg::SUM_BITS'(sample);
      prod  = aqbc_pkg::PROD_BITS'(total) * aqbc_pkg::PROD_BITS'(aqbc_pkg::DIV3_RECIP);
      avg   = prod[aqbc_pkg::DIV3_SHIFT +: aqbc_pkg::SAMPLE_BITS];

      dev0 = (cal_sample0 > avg) ? cal_sample0 - avg : avg - cal_sample0;
      dev1 = (cal_sample1 > avg) ? cal_sample1 - avg : avg - cal_sample1;
      dev2 = (sample > avg) ? sample - avg : avg - sample;

      range_bad = (avg > very_high_level) ||
                  (avg < aqbc_pkg::SAMPLE_BITS'(aqbc_pkg::CAL_MIN_LEVEL));
      dev_bad   = (dev0 > aqbc_pkg::SAMPLE_BITS'(aqbc_pkg::CAL_MAX_DEV)) ||
                  (dev1 > aqbc_pkg::SAMPLE_BITS'(aqbc_pkg::CAL_MAX_DEV)) ||
                  (dev2 > aqbc_pkg::SAMPLE_BITS'(aqbc_pkg::CAL_MAX_DEV));

      // A new calibration run drops the previous baseline and ready flag.
      ready_kept = first ? 1'b0 : ready;

      cal_out.store_en  = fill;
      cal_out.store_idx = count[0];
      if (fill) begin
         cal_out.status   = aqbc_pkg::STATUS_CALIBRATING;
         cal_out.baseline = first ? '0 : baseline;
         cal_out.ready    = ready_kept;
         cal_out.count    = count + 2'd1;
         cal_out.sum      = total;
      end else begin
         cal_out.baseline = avg;
         cal_out.count    = 2'd0;
         cal_out.sum      = '0;
         cal_out.ready    = ready_kept;
         if (range_bad) begin
            cal_out.status = aqbc_pkg::STATUS_OUT_OF_RANGE;
         end else if (dev_bad) begin
            cal_out.status = aqbc_pkg::STATUS_UNSTABLE;
         end else begin
            cal_out.status = aqbc_pkg::STATUS_OK;
            cal_out.ready  = 1'b1;
         end
      end
   end

endmodule

// File: design/aqbc_eval.sv
`timescale 1ns / 1ps

// Grades evaluate samples against the thresholds; tracks baseline toward samples below low_level.
module aqbc_eval (
   input  logic [1:0]                       mode,
   input  logic [aqbc_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [aqbc_pkg::SAMPLE_BITS-1:0] baseline,
   input  logic [aqbc_pkg::CFG_BITS-1:0]    very_high_level,
   input  logic [aqbc_pkg::CFG_BITS-1:0]    high_pollution_offset,
   input  logic [aqbc_pkg::CFG_BITS-1:0]    low_pollution_offset,
   output aqbc_pkg::eval_out_type           eval_out
);

   logic [aqbc_pkg::SAMPLE_BITS:0] high_level;
   logic [aqbc_pkg::SAMPLE_BITS:0] low_level;
   logic [aqbc_pkg::SAMPLE_BITS:0] mean_sum;

   always_comb begin
      // The signed rise over baseline exceeds an offset exactly when the
      // sample exceeds baseline plus that offset, so compare unwrapped sums.
      high_level = {1'b0, baseline} + {1'b0, high_pollution_offset};
      low_level  = {1'b0, baseline} + {1'b0, low_pollution_offset};
      mean_sum   = {1'b0, baseline} + {1'b0, sample};

      eval_out.quality = aqbc_pkg::QUALITY_GOOD;
      if (mode == aqbc_pkg::MODE_EVAL) begin
         if (sample > very_high_level) begin
            eval_out.quality = aqbc_pkg::QUALITY_VERY_HIGH;
         end else if ({1'b0, sample} > high_level) begin
            eval_out.quality = aqbc_pkg::QUALITY_HIGH;
         end else if ({1'b0, sample} > low_level) begin
            eval_out.quality = aqbc_pkg::QUALITY_LOW;
         end
      end

      if ({1'b0, sample} < low_level) begin
         eval_out.baseline = mean_sum[aqbc_pkg::SAMPLE_BITS:1];
      end else begin
         eval_out.baseline = baseline;
      end
   end

endmodule

// File: design/air_quality_baseline_classifier_core.sv
`timescale 1ns / 1ps

// Air quality baseline classifier.
// Samples arrive on the req_ channel (valid/ready) tagged with a mode:
// calibration, evaluate or raw read. Each accepted beat yields exactly one
// result beat on the rsp_ channel carrying quality, status, the baseline
// after the step and an echo of the sample.
// Three calibration beats set the baseline to their average and, if it
// passes the range and stability checks, arm the classifier; until then
// evaluate and raw beats answer not-initialized.
// The csr_ port writes the three thresholds; write only while idle.
// A beat is registered at the input, then processed into the result
// register and offered on rsp_. Throughput: one beat per cycle while the
// receiver takes results. The state (baseline, ready flag, calibration
// progress) is read and updated as the beat enters the result register,
// so back-to-back beats see each other's updates with no gap.
// When the receiver stalls, the result register holds and the input
// register fills; req_ready then drops until the result is taken.
// Reset (synchronous, active high) empties both stages, clears the baseline
// and calibration progress, and restores the threshold defaults.
module air_quality_baseline_classifier_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [aqbc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [aqbc_pkg::CFG_BITS-1:0]        csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic [aqbc_pkg::SAMPLE_BITS-1:0]     req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_quality,
   output logic [2:0]                           rsp_status,
   output logic [aqbc_pkg::SAMPLE_BITS-1:0]     rsp_reference,
   output logic [aqbc_pkg::SAMPLE_BITS-1:0]     rsp_raw_value
);

   // Configuration registers.
   logic [aqbc_pkg::CFG_BITS-1:0] bad_air_ff;
   logic [aqbc_pkg::CFG_BITS-1:0] high_ofs_ff;
   logic [aqbc_pkg::CFG_BITS-1:0] low_ofs_ff;

   // Input stage.
   logic                             in_valid_ff;
   logic [1:0]                       in_mode_ff;
   logic [aqbc_pkg::SAMPLE_BITS-1:0] in_sample_ff;

   // Block state.
   logic [aqbc_pkg::SAMPLE_BITS-1:0] baseline_ff;
   logic [aqbc_pkg::SAMPLE_BITS-1:0] baseline_in;
   logic                             ready_ff;
   logic                             ready_in;
   logic [1:0]                       cal_count_ff;
   logic [1:0]                       cal_count_in;
   logic [aqbc_pkg::SUM_BITS-1:0]    cal_sum_ff;
   logic [aqbc_pkg::SUM_BITS-1:0]    cal_sum_in;
   logic [aqbc_pkg::SAMPLE_BITS-1:0] cal_sample_ff [2];

   // Result stage.
   logic                             out_valid_ff;
   logic [1:0]                       out_quality_ff;
   logic [1:0]                       out_quality_in;
   logic [2:0]                       out_status_ff;
   logic [2:0]                       out_status_in;
   logic [aqbc_pkg::SAMPLE_BITS-1:0] out_reference_ff;
   logic [aqbc_pkg::SAMPLE_BITS-1:0] out_raw_ff;

   logic                   advance;
   logic                   accept;
   aqbc_pkg::cal_out_type  cal_out;
   aqbc_pkg::eval_out_type eval_out;

   // The input stage moves on whenever the result register is free or being
   // drained this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   aqbc_cal u_cal (
      .sample          (in_sample_ff),
      .count           (cal_count_ff),
      .sum             (cal_sum_ff),
      .ready           (ready_ff),
      .baseline        (baseline_ff),
      .cal_sample0     (cal_sample_ff[0]),
      .cal_sample1     (cal_sample_ff[1]),
      .very_high_level (bad_air_ff),
      .cal_out         (cal_out)
   );

   aqbc_eval u_eval (
      .mode                  (in_mode_ff),
      .sample                (in_sample_ff),
      .baseline              (baseline_ff),
      .very_high_level       (bad_air_ff),
      .high_pollution_offset (high_ofs_ff),
      .low_pollution_offset  (low_ofs_ff),
      .eval_out              (eval_out)
   );

   // Pick the next state and result for the beat in the input stage.
   always_comb begin
      baseline_in    = baseline_ff;
      ready_in       = ready_ff;
      cal_count_in   = cal_count_ff;
      cal_sum_in     = cal_sum_ff;
      out_quality_in = aqbc_pkg::QUALITY_GOOD;
      out_status_in  = aqbc_pkg::STATUS_OK;
      if (in_mode_ff == aqbc_pkg::MODE_CAL) begin
         baseline_in   = cal_out.baseline;
         ready_in      = cal_out.ready;
         cal_count_in  = cal_out.count;
         cal_sum_in    = cal_out.sum;
         out_status_in = cal_out.status;
      end else if (!ready_ff) begin
         // Not armed yet: report it and keep any calibration progress.
         out_status_in = aqbc_pkg::STATUS_NOT_INIT;
      end else begin
         baseline_in    = eval_out.baseline;
         out_quality_in = eval_out.quality;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bad_air_ff  <= aqbc_pkg::BAD_AIR_RESET;
         high_ofs_ff <= aqbc_pkg::HIGH_OFS_RESET;
         low_ofs_ff  <= aqbc_pkg::LOW_OFS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            aqbc_pkg::CSR_BAD_AIR:  bad_air_ff  <= csr_wdata;
            aqbc_pkg::CSR_HIGH_OFS: high_ofs_ff <= csr_wdata;
            aqbc_pkg::CSR_LOW_OFS:  low_ofs_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         baseline_ff  <= '0;
         ready_ff     <= 1'b0;
         cal_count_ff <= 2'd0;
         cal_sum_ff   <= '0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            out_valid_ff <= 1'b1;
            baseline_ff  <= baseline_in;
            ready_ff     <= ready_in;
            cal_count_ff <= cal_count_in;
            cal_sum_ff   <= cal_sum_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_mode_ff   <= req_mode;
         in_sample_ff <= req_sample;
      end
      if (advance) begin
         out_quality_ff   <= out_quality_in;
         out_status_ff    <= out_status_in;
         out_reference_ff <= baseline_in;
         out_raw_ff       <= in_sample_ff;
         if (in_mode_ff == aqbc_pkg::MODE_CAL && cal_out.store_en) begin
            cal_sample_ff[cal_out.store_idx] <= in_sample_ff;
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_quality   = out_quality_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_reference = out_reference_ff;
   assign rsp_raw_value = out_raw_ff;

endmodule

// File: tb/aqbc_reading_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the classifier, predicts each result beat from the
// accepted request beats and compares the outcome field by field.
module aqbc_reading_checker
   import aqbc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]    csr_index,
   input  logic [CFG_BITS-1:0]        csr_wdata,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [1:0]                 req_mode,
   input  logic [SAMPLE_BITS-1:0]     req_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [1:0]                 rsp_quality,
   input  logic [2:0]                 rsp_status,
   input  logic [SAMPLE_BITS-1:0]     rsp_reference,
   input  logic [SAMPLE_BITS-1:0]     rsp_raw_value,
   output int                         mismatch_count,
   output int                         outstanding
);

   typedef struct packed {
      quality_type            quality;
      status_type             status;
      logic [SAMPLE_BITS-1:0] reference;
      logic [SAMPLE_BITS-1:0] raw_value;
   } reading_type;

   reading_type pending_readings[$];

   logic [CFG_BITS-1:0]    bad_air_level;
   logic [CFG_BITS-1:0]    high_offset;
   logic [CFG_BITS-1:0]    low_offset;

   logic [SAMPLE_BITS-1:0] baseline;
   logic                   armed;
   logic [1:0]             cal_count;
   logic [SAMPLE_BITS-1:0] cal_held [2];
   logic [SUM_BITS-1:0]    cal_sum;

   function automatic int spread(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Advances the shadow state by one request beat and returns its result.
   function automatic reading_type classify_beat(input logic [1:0] mode,
                                                 input logic [SAMPLE_BITS-1:0] level);
      reading_type r;
      int avg;
      int rise;
      r.quality   = QUALITY_GOOD;
      r.status    = STATUS_OK;
      if (mode == MODE_CAL) begin
         if (cal_count == 0) begin
            armed    = 1'b0;
            baseline = '0;
            cal_sum  = '0;
         end
         if (cal_count < CAL_SAMPLES - 1) begin
            cal_held[cal_count[0]] = level;
            cal_sum   = cal_sum + SUM_BITS'(level);
            cal_count = cal_count + 2'd1;
            r.status  = STATUS_CALIBRATING;
         end else begin
            avg       = (int'(cal_sum) + int'(level)) / CAL_SAMPLES;
            baseline  = avg[SAMPLE_BITS-1:0];
            cal_count = '0;
            cal_sum   = '0;
            if (avg > int'(bad_air_level) || avg < CAL_MIN_LEVEL) begin
               r.status = STATUS_OUT_OF_RANGE;
            end else if (spread(int'(cal_held[0]), avg) > CAL_MAX_DEV ||
                         spread(int'(cal_held[1]), avg) > CAL_MAX_DEV ||
                         spread(int'(level), avg) > CAL_MAX_DEV) begin
               r.status = STATUS_UNSTABLE;
            end else begin
               armed    = 1'b1;
               r.status = STATUS_OK;
            end
         end
      end else if (!armed) begin
         r.status = STATUS_NOT_INIT;
      end else begin
         if (mode == MODE_EVAL) begin
            rise = int'(level) - int'(baseline);
            if (level > bad_air_level)          r.quality = QUALITY_VERY_HIGH;
            else if (rise > int'(high_offset))  r.quality = QUALITY_HIGH;
            else if (rise > int'(low_offset))   r.quality = QUALITY_LOW;
            else                                r.quality = QUALITY_GOOD;
         end
         // Tracking averages the baseline with any level below baseline plus low offset.
         if (int'(level) < int'(low_offset) + int'(baseline))
            baseline = SAMPLE_BITS'((int'(baseline) + int'(level)) >> 1);
      end
      r.reference = baseline;
      r.raw_value = level;
      return r;
   endfunction

   task automatic check_field(input string what, input logic [SAMPLE_BITS-1:0] want,
                              input logic [SAMPLE_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         bad_air_level  = BAD_AIR_RESET;
         high_offset    = HIGH_OFS_RESET;
         low_offset     = LOW_OFS_RESET;
         baseline       = '0;
         armed          = 1'b0;
         cal_count      = '0;
         cal_held[0]    = '0;
         cal_held[1]    = '0;
         cal_sum        = '0;
         mismatch_count = 0;
         pending_readings.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BAD_AIR:  bad_air_level = csr_wdata;
               CSR_HIGH_OFS: high_offset   = csr_wdata;
               CSR_LOW_OFS:  low_offset    = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pending_readings.push_back(classify_beat(req_mode, req_sample));
         if (rsp_valid && rsp_ready) begin
            if (pending_readings.size() == 0) begin
               $display("%0t: unexpected result beat: expected none, actual status %0d ref %0d",
                        $time, rsp_status, rsp_reference);
               mismatch_count++;
            end else begin
               want = pending_readings.pop_front();
               check_field("quality", SAMPLE_BITS'(want.quality),
                           SAMPLE_BITS'(rsp_quality));
               check_field("status", SAMPLE_BITS'(want.status),
                           SAMPLE_BITS'(rsp_status));
               check_field("reference", want.reference, rsp_reference);
               check_field("raw_value", want.raw_value, rsp_raw_value);
            end
         end
      end
      outstanding <= pending_readings.size();
   end

endmodule

// File: tb/tb_air_quality_baseline_classifier_core.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the air quality classifier. A checker instance
// beside the block does all prediction and comparison; this module only
// drives beats and stalls, sets thresholds per phase and reports the outcome.
module tb_air_quality_baseline_classifier_core;
   import aqbc_pkg::*;

   // Mode three has no name in the package; the block treats it as raw read.
   localparam logic [1:0] MODE_RAW_ALIAS = 2'd3;
   localparam int         RUN_LIMIT_NS   = 2_000_000;
   localparam int         DRAIN_CYCLES   = 8;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_BAD_AIR;
   logic [CFG_BITS-1:0]     csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_mode = MODE_CAL;
   logic [SAMPLE_BITS-1:0]  req_sample = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_quality;
   logic [2:0]              rsp_status;
   logic [SAMPLE_BITS-1:0]  rsp_reference;
   logic [SAMPLE_BITS-1:0]  rsp_raw_value;

   int mismatch_count;
   int outstanding;

   // Threshold values as last programmed; used to aim samples at the edges.
   int cfg_bad  = BAD_AIR_RESET;
   int cfg_high = HIGH_OFS_RESET;
   int cfg_low  = LOW_OFS_RESET;
   // Center of the most recent calibration, a rough guess of the baseline.
   int cal_center = 0;
   int beats_sent = 0;

   // While choppy is set both sides throw in stall bursts; calm shuts them
   // off for good in the last phase.
   logic choppy = 1'b1;
   logic calm   = 1'b0;
   int   stall_left = 0;

   air_quality_baseline_classifier_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_quality   (rsp_quality),
      .rsp_status    (rsp_status),
      .rsp_reference (rsp_reference),
      .rsp_raw_value (rsp_raw_value)
   );

   aqbc_reading_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_quality    (rsp_quality),
      .rsp_status     (rsp_status),
      .rsp_reference  (rsp_reference),
      .rsp_raw_value  (rsp_raw_value),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: ready drops in random stall bursts. The choppy flag
   // flips now and then so that long stretches run with no stalls at all.
   always @(posedge clock) begin
      if ($urandom_range(0, 49) == 0)
         choppy <= ~choppy;
      if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_ready  <= 1'b1;
      end else if (!calm && choppy && $urandom_range(0, 3) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(1, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [SAMPLE_BITS-1:0] clip_level(input int v);
      if (v < 0)    return '0;
      if (v > 1023) return '1;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // Offers one request beat and returns at the edge that accepts it. Valid
   // is left high so the next beat can follow with no bubble.
   task automatic offer_sample(input logic [1:0] mode, input int level);
      int gap;
      gap = (choppy && !calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_sample <= clip_level(level);
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // Lowers valid and waits until every predicted result beat has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Writes all three threshold registers on consecutive cycles, idle only.
   task automatic program_thresholds(input int bad, input int high, input int low);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BAD_AIR;
      csr_wdata <= bad[CFG_BITS-1:0];
      @(posedge clock);
      csr_index <= CSR_HIGH_OFS;
      csr_wdata <= high[CFG_BITS-1:0];
      @(posedge clock);
      csr_index <= CSR_LOW_OFS;
      csr_wdata <= low[CFG_BITS-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_bad  = bad;
      cfg_high = high;
      cfg_low  = low;
   endtask

   // Evaluate levels: half around the grade boundaries of the current
   // baseline guess, some below it to exercise tracking, some above or anywhere.
   function automatic int pick_probe();
      case ($urandom_range(0, 5))
         0:       return int'($urandom_range(0, 1023));
         1:       return cal_center + cfg_low + int'($urandom_range(0, 4)) - 2;
         2:       return cal_center + cfg_high + int'($urandom_range(0, 4)) - 2;
         3:       return cfg_bad + int'($urandom_range(0, 4)) - 2;
         4:       return cal_center - int'($urandom_range(0, 200));
         default: return cal_center + int'($urandom_range(0, 600));
      endcase
   endfunction

   function automatic int pick_center();
      case ($urandom_range(0, 9))
         0:       return int'($urandom_range(0, 14));
         1:       return int'($urandom_range(1005, 1023));
         2:       return cfg_bad + int'($urandom_range(0, 6)) - 3;
         default: return (cfg_bad >= CAL_MIN_LEVEL) ?
                         int'($urandom_range(CAL_MIN_LEVEL, cfg_bad)) :
                         int'($urandom_range(0, 1023));
      endcase
   endfunction

   task automatic noise_beat();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)      offer_sample(MODE_EVAL, pick_probe());
      else if (pick < 90) offer_sample(MODE_RAW, pick_probe());
      else                offer_sample(MODE_RAW_ALIAS, pick_probe());
   endtask

   // Three calibration beats around one center. A tight spread mostly passes
   // the stability test; a wide one mostly fails it. Now and then another
   // beat cuts in, or the sequence is abandoned part way.
   task automatic run_calibration();
      int center;
      int width;
      center = pick_center();
      width  = ($urandom_range(0, 4) == 0) ? 30 : 8;
      cal_center = center;
      for (int k = 0; k < CAL_SAMPLES; k++) begin
         if (k > 0 && $urandom_range(0, 9) == 0) noise_beat();
         if (k > 0 && $urandom_range(0, 19) == 0) return;
         offer_sample(MODE_CAL, center + int'($urandom_range(0, 2 * width)) - width);
      end
   endtask

   task automatic random_traffic(input int count);
      int target;
      target = beats_sent + count;
      while (beats_sent < target) begin
         if ($urandom_range(0, 99) < 20) run_calibration();
         else                            noise_beat();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Before any calibration, evaluate and raw read answer not-initialized.
      offer_sample(MODE_EVAL, 512);
      offer_sample(MODE_RAW, 1023);
      // An all-zero calibration averages below the minimum level.
      offer_sample(MODE_CAL, 0);
      offer_sample(MODE_CAL, 0);
      offer_sample(MODE_CAL, 0);
      // A full-scale calibration lands above the bad-air threshold.
      offer_sample(MODE_CAL, 1023);
      offer_sample(MODE_CAL, 1023);
      offer_sample(MODE_CAL, 1023);
      // One sample strays 17 from the average: unstable, still not armed.
      offer_sample(MODE_CAL, 100);
      offer_sample(MODE_CAL, 132);
      offer_sample(MODE_CAL, 115);
      offer_sample(MODE_EVAL, 115);
      // Deviations of exactly 15 still pass; baseline becomes 115.
      offer_sample(MODE_CAL, 100);
      offer_sample(MODE_CAL, 130);
      offer_sample(MODE_CAL, 115);
      // Each grade; the first good one sits at the boundary where tracking just does not fire.
      offer_sample(MODE_EVAL, 516);
      offer_sample(MODE_EVAL, 316);
      offer_sample(MODE_EVAL, 315);
      offer_sample(MODE_EVAL, 701);
      offer_sample(MODE_EVAL, 0);
      offer_sample(MODE_RAW, 3);
      offer_sample(MODE_RAW_ALIAS, 90);
      // A calibration interrupted by an evaluate keeps its progress.
      offer_sample(MODE_CAL, 300);
      offer_sample(MODE_EVAL, 300);
      offer_sample(MODE_CAL, 300);
      offer_sample(MODE_CAL, 300);

      random_traffic(140);
      program_thresholds(1023, 1023, 1023);
      random_traffic(135);
      program_thresholds(0, 0, 0);
      random_traffic(100);
      program_thresholds($urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1023));
      random_traffic(135);
      program_thresholds(1023, 0, 0);
      random_traffic(135);
      program_thresholds($urandom_range(300, 1023), $urandom_range(0, 600),
                         $urandom_range(0, 300));
      random_traffic(135);

      // Last phase: back to defaults and full throughput on both sides.
      program_thresholds(BAD_AIR_RESET, HIGH_OFS_RESET, LOW_OFS_RESET);
      calm = 1'b1;
      random_traffic(135);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** air_quality_baseline_classifier_core: PASSED **");
      end else begin
         $display("** air_quality_baseline_classifier_core: FAILED **");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(RUN_LIMIT_NS);
      $display("** air_quality_baseline_classifier_core: FAILED **");
      $finish;
   end

endmodule
